@@ hw/rtl/plac_pkg.sv @@
// Shared types and constants for the polyline length accumulator.
package plac_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_ADD,
    ST_DONE
  } plac_state_e;

  localparam int unsigned TallyWidth = 2;
  localparam logic [TallyWidth-1:0] TallyNone = 2'd0;
  localparam logic [TallyWidth-1:0] TallyOne  = 2'd1;
  localparam logic [TallyWidth-1:0] TallyTwo  = 2'd2;
  localparam logic [TallyWidth-1:0] TallyFull = 2'd3;

  localparam int unsigned AxisCount = 3;

endpackage

@@ hw/rtl/plac_if.sv @@
// Valid/ready channel interfaces for vertex, result and configuration words.
interface plac_vertex_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          starts_line;
  logic                          ends_line;

  modport source (output valid, pos_x, pos_y, pos_z, starts_line, ends_line, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, starts_line, ends_line, output ready);
endinterface

interface plac_result_if #(
  parameter int unsigned LENGTH_WIDTH = 40
);
  logic                    valid;
  logic                    ready;
  logic [LENGTH_WIDTH-1:0] total_length;
  logic                    complete;
  logic                    overflowed;

  modport source (output valid, total_length, complete, overflowed, input ready);
  modport sink   (input valid, total_length, complete, overflowed, output ready);
endinterface

interface plac_cfg_if;
  logic valid;
  logic ready;
  logic closed_loop;

  modport source (output valid, closed_loop, input ready);
  modport sink   (input valid, closed_loop, output ready);
endinterface

@@ hw/rtl/polyline_length_accumulator_unit.sv @@
// Polyline length accumulator: top level with sequencer and shared square/root unit.
//
// vertex_i takes one vertex word per polyline point; result_o returns one
// word per vertex with the running length, the end mark and the sticky
// saturation flag. cfg_i writes closed_loop and is always ready.
// A vertex that opens a polyline goes from accept straight to the output
// load. Any other vertex runs one segment: differences and squares
// through the single multiplier, the bit-serial square root over
// COORD_WIDTH+1 result bits, the saturating add and the output load.
// A closed polyline runs a second segment on its last vertex, back to
// its first vertex. vertex_i is ready only while the sequencer is idle;
// the root loop sets the item time.
// Reset clears the polyline state, closed_loop and the result valid flag.
// When the receiver stalls, the result word holds in the output register
// and the next vertex is still taken; its own result waits at the end of
// its run until the register is free.
module polyline_length_accumulator_unit #(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned LENGTH_WIDTH = 40
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  plac_vertex_if.sink   vertex_i,
  plac_result_if.source result_o,
  plac_cfg_if.sink      cfg_i
);
  import plac_pkg::*;

  localparam int unsigned RootWidth = COORD_WIDTH + 1;
  localparam int unsigned RadWidth  = 2 * RootWidth;
  localparam int unsigned SqWidth   = 2 * COORD_WIDTH;
  localparam int unsigned RemWidth  = RootWidth + 1;
  localparam int unsigned TrialWidth = RootWidth + 3;
  localparam int unsigned CntWidth  = $clog2(RootWidth);
  localparam int unsigned ExtWidth  = (LENGTH_WIDTH > RootWidth ? LENGTH_WIDTH : RootWidth) + 1;

  plac_state_e state_q, state_d;

  logic                    closed_loop_q;
  logic [COORD_WIDTH-1:0]  first_x_q, first_y_q, first_z_q;
  logic [COORD_WIDTH-1:0]  prev_x_q, prev_y_q, prev_z_q;
  logic [COORD_WIDTH-1:0]  cur_x_q, cur_y_q, cur_z_q;
  logic [TallyWidth-1:0]   tally_q;
  logic [LENGTH_WIDTH-1:0] len_q;
  logic                    sat_q;
  logic                    ends_q;
  logic                    closing_q;
  logic [CntWidth-1:0]     cnt_q;
  logic [COORD_WIDTH-1:0]  mag_q;
  logic [SqWidth-1:0]      sq_q;
  logic [RadWidth-1:0]     acc_q;
  logic [RemWidth-1:0]     rem_q;
  logic [RootWidth-1:0]    root_q;

  logic                    out_valid_q;
  logic [LENGTH_WIDTH-1:0] out_length_q;
  logic                    out_complete_q;
  logic                    out_overflow_q;

  logic                    in_accept;
  logic                    new_line;
  logic                    out_load;
  logic [COORD_WIDTH-1:0]  op_a, op_b;
  logic [COORD_WIDTH:0]    diff, diff_neg;
  logic [COORD_WIDTH-1:0]  mag;
  logic [TrialWidth-1:0]   rem_shift, trial, rem_sub;
  logic                    root_bit;
  logic [ExtWidth-1:0]     sum_ext;
  logic                    sum_over;
  logic                    close_next;

  assign vertex_i.ready = (state_q == ST_IDLE);
  assign in_accept      = vertex_i.valid && vertex_i.ready;
  assign new_line       = vertex_i.starts_line || (tally_q == TallyNone);
  assign cfg_i.ready    = 1'b1;
  assign out_load       = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin
        op_a = closing_q ? cur_x_q : prev_x_q;
        op_b = closing_q ? first_x_q : cur_x_q;
      end
      2'd1: begin
        op_a = closing_q ? cur_y_q : prev_y_q;
        op_b = closing_q ? first_y_q : cur_y_q;
      end
      default: begin
        op_a = closing_q ? cur_z_q : prev_z_q;
        op_b = closing_q ? first_z_q : cur_z_q;
      end
    endcase
  end

  assign diff     = {op_b[COORD_WIDTH-1], op_b} - {op_a[COORD_WIDTH-1], op_a};
  assign diff_neg = ~diff + 1'b1;
  assign mag      = diff[COORD_WIDTH] ? diff_neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];

  assign rem_shift = {rem_q, acc_q[RadWidth-1 -: 2]};
  assign trial     = TrialWidth'({root_q, 2'b01});
  assign root_bit  = (rem_shift >= trial);
  assign rem_sub   = root_bit ? (rem_shift - trial) : rem_shift;

  assign sum_ext    = ExtWidth'(len_q) + ExtWidth'(root_q);
  assign sum_over   = sum_ext > ExtWidth'({LENGTH_WIDTH{1'b1}});
  assign close_next = !closing_q && ends_q && closed_loop_q && (tally_q >= TallyTwo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = new_line ? ST_DONE : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (cnt_q == CntWidth'(4)) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt_q == CntWidth'(RootWidth - 1)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = close_next ? ST_SQUARE : ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_loop_q <= 1'b0;
      first_x_q     <= '0;
      first_y_q     <= '0;
      first_z_q     <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_z_q      <= '0;
      tally_q       <= TallyNone;
      len_q         <= '0;
      sat_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
      closing_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        closed_loop_q <= cfg_i.closed_loop;
      end
      if (in_accept) begin
        cnt_q     <= '0;
        closing_q <= 1'b0;
        if (new_line) begin
          first_x_q <= vertex_i.pos_x;
          first_y_q <= vertex_i.pos_y;
          first_z_q <= vertex_i.pos_z;
          prev_x_q  <= vertex_i.pos_x;
          prev_y_q  <= vertex_i.pos_y;
          prev_z_q  <= vertex_i.pos_z;
          tally_q   <= TallyOne;
          len_q     <= '0;
          sat_q     <= 1'b0;
        end
      end
      if (state_q == ST_SQUARE) begin
        cnt_q <= (cnt_q == CntWidth'(4)) ? '0 : cnt_q + 1'b1;
      end
      if (state_q == ST_ROOT) begin
        cnt_q <= (cnt_q == CntWidth'(RootWidth - 1)) ? '0 : cnt_q + 1'b1;
      end
      if (state_q == ST_ADD) begin
        if (sum_over) begin
          len_q <= '1;
          sat_q <= 1'b1;
        end else begin
          len_q <= sum_ext[LENGTH_WIDTH-1:0];
        end
        if (!closing_q) begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          prev_z_q <= cur_z_q;
          if (tally_q != TallyFull) begin
            tally_q <= tally_q + 1'b1;
          end
        end
        closing_q <= close_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (ends_q) begin
          tally_q <= TallyNone;
        end
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_x_q <= vertex_i.pos_x;
      cur_y_q <= vertex_i.pos_y;
      cur_z_q <= vertex_i.pos_z;
      ends_q  <= vertex_i.ends_line;
      acc_q   <= '0;
    end
    if (state_q == ST_SQUARE) begin
      if (cnt_q < CntWidth'(AxisCount)) begin
        mag_q <= mag;
      end
      if (cnt_q >= CntWidth'(1) && cnt_q <= CntWidth'(AxisCount)) begin
        sq_q <= SqWidth'(mag_q) * SqWidth'(mag_q);
      end
      if (cnt_q >= CntWidth'(2)) begin
        acc_q <= acc_q + RadWidth'(sq_q);
      end
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == ST_ROOT) begin
      acc_q  <= {acc_q[RadWidth-3:0], 2'b00};
      rem_q  <= rem_sub[RemWidth-1:0];
      root_q <= {root_q[RootWidth-2:0], root_bit};
    end
    if (state_q == ST_ADD) begin
      acc_q <= '0;
    end
    if (out_load) begin
      out_length_q   <= len_q;
      out_complete_q <= ends_q;
      out_overflow_q <= sat_q;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.total_length = out_length_q;
  assign result_o.complete     = out_complete_q;
  assign result_o.overflowed   = out_overflow_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != ST_IDLE)
    else $error("sequencer stayed idle after a vertex word");

  a_overflow_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_overflow_q |-> out_length_q == {LENGTH_WIDTH{1'b1}})
    else $error("saturated result below maximum length");

  a_root_has_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT |-> tally_q != TallyNone)
    else $error("segment running with no open polyline");

  a_close_needs_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQUARE && closing_q |-> tally_q == TallyFull && ends_q)
    else $error("closing segment on a short or unfinished polyline");
`endif

endmodule
